[hw/rtl/pwnd_pkg.sv]
// Shared constants, register indexes and result type for the pulse width nibble decoder.
package pwnd_pkg;

    localparam int PULSE_COUNT_BITS_DEF = 16;
    localparam int AGE_COUNT_BITS_DEF   = 24;

    localparam int LIMIT_BITS   = 16;
    localparam int TIMEOUT_BITS = 24;
    localparam int CFG_IDX_BITS = 8;
    localparam int CFG_DATA_BITS = 24;
    localparam int NIBBLE_BITS  = 4;
    localparam int PHASE_BITS   = 2;
    localparam int STATUS_BITS  = 2;

    localparam logic [LIMIT_BITS-1:0]   ONE_LIMIT_RST      = 16'd150;
    localparam logic [LIMIT_BITS-1:0]   GAP_LIMIT_RST      = 16'd900;
    localparam logic [LIMIT_BITS-1:0]   LONG_GAP_LIMIT_RST = 16'd2000;
    localparam logic [TIMEOUT_BITS-1:0] STATUS_TIMEOUT_RST = 24'd1000000;

    localparam logic [CFG_IDX_BITS-1:0] REG_ONE_LIMIT      = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_GAP_LIMIT      = 8'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_LONG_GAP_LIMIT = 8'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_STATUS_TIMEOUT = 8'd3;

    localparam logic [STATUS_BITS-1:0] LINK_RECENT  = 2'd0;
    localparam logic [STATUS_BITS-1:0] LINK_NEVER   = 2'd1;
    localparam logic [STATUS_BITS-1:0] LINK_STOPPED = 2'd2;

    localparam logic [PHASE_BITS-1:0] PHASE_LAST = 2'd3;

    typedef struct packed {
        logic                   nibble_valid;
        logic [NIBBLE_BITS-1:0] nibble;
        logic                   frame_gap;
        logic                   long_gap;
        logic                   framing_error;
        logic [STATUS_BITS-1:0] link_status;
    } result_t;

endpackage

[hw/rtl/pwnd_decode.sv]
// Single-sample decode step: pulse timing, bit shifting, gap checks and link status.
module pwnd_decode #(
    parameter int PULSE_COUNT_BITS = pwnd_pkg::PULSE_COUNT_BITS_DEF,
    parameter int AGE_COUNT_BITS   = pwnd_pkg::AGE_COUNT_BITS_DEF
) (
    input  logic                                line_level,
    input  logic                                previous_level,
    input  logic [PULSE_COUNT_BITS-1:0]         low_width,
    input  logic [pwnd_pkg::PHASE_BITS-1:0]     bit_phase,
    input  logic [pwnd_pkg::NIBBLE_BITS-1:0]    partial_nibble,
    input  logic [AGE_COUNT_BITS-1:0]           data_age,
    input  logic                                ever_sent,
    input  logic [pwnd_pkg::LIMIT_BITS-1:0]     one_limit,
    input  logic [pwnd_pkg::LIMIT_BITS-1:0]     gap_limit,
    input  logic [pwnd_pkg::LIMIT_BITS-1:0]     long_gap_limit,
    input  logic [pwnd_pkg::TIMEOUT_BITS-1:0]   status_timeout,
    output logic [PULSE_COUNT_BITS-1:0]         low_width_next,
    output logic [pwnd_pkg::PHASE_BITS-1:0]     bit_phase_next,
    output logic [pwnd_pkg::NIBBLE_BITS-1:0]    partial_nibble_next,
    output logic [AGE_COUNT_BITS-1:0]           data_age_next,
    output logic                                ever_sent_next,
    output pwnd_pkg::result_t                   result
);
    import pwnd_pkg::*;

    localparam int W_CMP = (PULSE_COUNT_BITS > LIMIT_BITS) ? PULSE_COUNT_BITS : LIMIT_BITS;
    localparam int A_CMP = (AGE_COUNT_BITS > TIMEOUT_BITS) ? AGE_COUNT_BITS : TIMEOUT_BITS;
    localparam logic [PULSE_COUNT_BITS-1:0] PULSE_MAX = {PULSE_COUNT_BITS{1'b1}};
    localparam logic [AGE_COUNT_BITS-1:0]   AGE_MAX   = {AGE_COUNT_BITS{1'b1}};

    logic [W_CMP-1:0] width_cmp;
    logic             is_gap;
    logic             is_long;
    logic             is_one;
    logic [AGE_COUNT_BITS-1:0] age_inc;

    assign width_cmp = W_CMP'(low_width);
    assign is_gap    = width_cmp > W_CMP'(gap_limit);
    assign is_long   = width_cmp > W_CMP'(long_gap_limit);
    assign is_one    = width_cmp < W_CMP'(one_limit);
    assign age_inc   = (data_age != AGE_MAX) ? data_age + 1'b1 : data_age;

    always_comb
    begin
        low_width_next      = low_width;
        bit_phase_next      = bit_phase;
        partial_nibble_next = partial_nibble;
        data_age_next       = age_inc;
        ever_sent_next      = ever_sent;
        result              = '0;

        if (!line_level)
        begin
            if (previous_level)
            begin
                low_width_next = PULSE_COUNT_BITS'(1);
            end
            else if (low_width != PULSE_MAX)
            begin
                low_width_next = low_width + 1'b1;
            end
        end
        else if (!previous_level)
        begin
            if (is_gap)
            begin
                // frame gap: report and drop any partial nibble
                result.frame_gap     = 1'b1;
                result.framing_error = (bit_phase != '0);
                result.long_gap      = is_long;
                bit_phase_next       = '0;
                partial_nibble_next  = '0;
            end
            else
            begin
                bit_phase_next = bit_phase + 1'b1;
                if (bit_phase == PHASE_LAST)
                begin
                    result.nibble_valid = 1'b1;
                    result.nibble       = {partial_nibble[NIBBLE_BITS-2:0], is_one};
                    partial_nibble_next = '0;
                    data_age_next       = '0;
                    ever_sent_next      = 1'b1;
                end
                else
                begin
                    partial_nibble_next = {partial_nibble[NIBBLE_BITS-2:0], is_one};
                end
            end
        end

        if (A_CMP'(data_age_next) < A_CMP'(status_timeout))
        begin
            result.link_status = LINK_RECENT;
        end
        else if (!ever_sent_next)
        begin
            result.link_status = LINK_NEVER;
        end
        else
        begin
            result.link_status = LINK_STOPPED;
        end
    end

endmodule

[hw/rtl/pulse_width_nibble_decoder_core.sv]
// Top level of the pulse width nibble decoder: handshakes, configuration, state and result register.
// The block takes one line sample per transfer (one per microsecond tick) and returns one result
// per sample. Each sample is decoded in a single combinational pass from the decoder state
// registers into an output register, so one sample is accepted every clock cycle as long as the
// result side keeps taking transfers; a result appears in the cycle after its sample is accepted.
// Low pulses are timed with a saturating counter; on the rising edge a pulse longer than
// gap_limit ends a frame (with framing_error if a nibble was partly received, and long_gap if it
// also exceeds long_gap_limit), and any shorter pulse shifts in a one (below one_limit) or a zero.
// Every fourth bit emits a nibble, first bit most significant. link_status reports recent data,
// never sent, or stopped, using an age counter against status_timeout. Configuration writes take
// effect at the next edge and should be made while the block is idle; unknown indexes are ignored.
module pulse_width_nibble_decoder_core #(
    parameter int PULSE_COUNT_BITS = pwnd_pkg::PULSE_COUNT_BITS_DEF,
    parameter int AGE_COUNT_BITS   = pwnd_pkg::AGE_COUNT_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [pwnd_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [pwnd_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 line_level,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 nibble_valid,
    output logic [pwnd_pkg::NIBBLE_BITS-1:0]     nibble,
    output logic                                 frame_gap,
    output logic                                 long_gap,
    output logic                                 framing_error,
    output logic [pwnd_pkg::STATUS_BITS-1:0]     link_status
);
    import pwnd_pkg::*;

    // configuration registers
    logic [LIMIT_BITS-1:0]   one_limit_reg;
    logic [LIMIT_BITS-1:0]   gap_limit_reg;
    logic [LIMIT_BITS-1:0]   long_gap_limit_reg;
    logic [TIMEOUT_BITS-1:0] status_timeout_reg;

    // decoder state
    logic                        previous_level_reg;
    logic [PULSE_COUNT_BITS-1:0] low_width_reg,      low_width_next;
    logic [PHASE_BITS-1:0]       bit_phase_reg,      bit_phase_next;
    logic [NIBBLE_BITS-1:0]      partial_nibble_reg, partial_nibble_next;
    logic [AGE_COUNT_BITS-1:0]   data_age_reg,       data_age_next;
    logic                        ever_sent_reg,      ever_sent_next;

    // output stage
    logic    out_valid_reg;
    result_t result_reg;
    result_t result_next;
    logic    in_xfer;

    // Take a new sample whenever the output register is empty or being drained this cycle.
    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_limit_reg      <= ONE_LIMIT_RST;
            gap_limit_reg      <= GAP_LIMIT_RST;
            long_gap_limit_reg <= LONG_GAP_LIMIT_RST;
            status_timeout_reg <= STATUS_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ONE_LIMIT:      one_limit_reg      <= cfg_data[LIMIT_BITS-1:0];
                REG_GAP_LIMIT:      gap_limit_reg      <= cfg_data[LIMIT_BITS-1:0];
                REG_LONG_GAP_LIMIT: long_gap_limit_reg <= cfg_data[LIMIT_BITS-1:0];
                REG_STATUS_TIMEOUT: status_timeout_reg <= cfg_data[TIMEOUT_BITS-1:0];
                default:            ;  // drop writes to unknown indexes
            endcase
        end
    end

    pwnd_decode #(
        .PULSE_COUNT_BITS (PULSE_COUNT_BITS),
        .AGE_COUNT_BITS   (AGE_COUNT_BITS)
    ) u_decode (
        .line_level          (line_level),
        .previous_level      (previous_level_reg),
        .low_width           (low_width_reg),
        .bit_phase           (bit_phase_reg),
        .partial_nibble      (partial_nibble_reg),
        .data_age            (data_age_reg),
        .ever_sent           (ever_sent_reg),
        .one_limit           (one_limit_reg),
        .gap_limit           (gap_limit_reg),
        .long_gap_limit      (long_gap_limit_reg),
        .status_timeout      (status_timeout_reg),
        .low_width_next      (low_width_next),
        .bit_phase_next      (bit_phase_next),
        .partial_nibble_next (partial_nibble_next),
        .data_age_next       (data_age_next),
        .ever_sent_next      (ever_sent_next),
        .result              (result_next)
    );

    // Advance decoder state only on an accepted sample; hold it otherwise.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            previous_level_reg <= 1'b1;
            low_width_reg      <= '0;
            bit_phase_reg      <= '0;
            partial_nibble_reg <= '0;
            data_age_reg       <= '0;
            ever_sent_reg      <= 1'b0;
        end
        else if (in_xfer)
        begin
            previous_level_reg <= line_level;
            low_width_reg      <= low_width_next;
            bit_phase_reg      <= bit_phase_next;
            partial_nibble_reg <= partial_nibble_next;
            data_age_reg       <= data_age_next;
            ever_sent_reg      <= ever_sent_next;
        end
    end

    // Output valid: set on an accepted sample, clear once the result transfers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign nibble_valid  = result_reg.nibble_valid;
    assign nibble        = result_reg.nibble;
    assign frame_gap     = result_reg.frame_gap;
    assign long_gap      = result_reg.long_gap;
    assign framing_error = result_reg.framing_error;
    assign link_status   = result_reg.link_status;

    // A nibble and a frame gap never come from the same sample.
    a_nibble_or_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(nibble_valid && frame_gap))
        else $error("nibble and frame gap reported together");

    // Gap qualifiers only accompany a frame gap.
    a_gap_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !frame_gap) |-> (!long_gap && !framing_error))
        else $error("gap flags without a frame gap");

    // An accepted sample always leaves a result waiting.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> out_valid)
        else $error("accepted sample produced no result");

    // An emitted nibble leaves the bit phase on a nibble boundary.
    a_phase_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && result_next.nibble_valid) |=> (bit_phase_reg == '0))
        else $error("bit phase not cleared after nibble");

endmodule
